@@ design/plst_pkg.sv @@
// Package for the positional list store: field widths, operation and status
// codes, controller states and the command/status structs.
// No dependencies.
package plst_pkg;

  localparam int MODE_W = 3;
  localparam int POS_W  = 8;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND   = 3'd0,
    MODE_INSERT   = 3'd1,
    MODE_DEL_LAST = 3'd2,
    MODE_DEL_AT   = 3'd3,
    MODE_READ     = 3'd4
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
  } ctl_t;

  typedef struct packed {
    logic more;
  } sts_t;

endpackage

@@ design/positional_list_store_core.sv @@
// Positional list store top level: ordered list of signed values with
// append, insert, delete and read-out. Joins plst_ctrl and plst_datapath.
// The command is registered at the accepting edge; the first result is registered in execute.
// A single-result command passes through accept and execute, then idle takes the next;
// a read-out gives one beat per value from the cell rotation.
// Reset: count cleared, controller idle; cell contents undefined until written.
// Results cannot be stalled; busy_o is high while a command is in flight.
module positional_list_store_core #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [plst_pkg::MODE_W-1:0]         mode_i,
  input  logic [plst_pkg::POS_W-1:0]          position_i,
  input  logic signed [plst_pkg::VAL_W-1:0]   value_i,
  output logic                                valid_o,
  output logic [plst_pkg::STAT_W-1:0]         status_o,
  output logic [plst_pkg::CNT_W-1:0]          count_o,
  output logic signed [plst_pkg::VAL_W-1:0]   element_o,
  output logic                                last_o
);
  import plst_pkg::*;

  ctl_t ctl;
  sts_t sts;

  plst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy_o (busy_o)
  );

  plst_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .sts_o     (sts),
    .mode_i    (mode_i),
    .position_i(position_i),
    .value_i   (value_i),
    .valid_o   (valid_o),
    .status_o  (status_o),
    .count_o   (count_o),
    .element_o (element_o),
    .last_o    (last_o)
  );

endmodule

@@ design/plst_ctrl.sv @@
// Controller for the positional list store: sequences load, execute and
// read-out beats. Depends on plst_pkg.
module plst_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  plst_pkg::sts_t   sts_i,
  output plst_pkg::ctl_t   ctl_o,
  output logic             busy_o
);
  import plst_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl_o.exec = 1'b1;
        state_d    = sts_i.more ? S_READ : S_IDLE;
      end
      S_READ: begin
        ctl_o.step = 1'b1;
        state_d    = sts_i.more ? S_READ : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/plst_datapath.sv @@
// Datapath for the positional list store: command registers, the row of
// shifting cells, the count, the read-out index and the result registers.
// Depends on plst_pkg.
module plst_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  plst_pkg::ctl_t                      ctl_i,
  output plst_pkg::sts_t                      sts_o,
  input  logic [plst_pkg::MODE_W-1:0]         mode_i,
  input  logic [plst_pkg::POS_W-1:0]          position_i,
  input  logic signed [plst_pkg::VAL_W-1:0]   value_i,
  output logic                                valid_o,
  output logic [plst_pkg::STAT_W-1:0]         status_o,
  output logic [plst_pkg::CNT_W-1:0]          count_o,
  output logic signed [plst_pkg::VAL_W-1:0]   element_o,
  output logic                                last_o
);
  import plst_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CW_ONE = {{(CW-1){1'b0}}, 1'b1};
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);

  logic [MODE_W-1:0]        mode_q;
  logic [POS_W-1:0]         pos_q;
  logic signed [VAL_W-1:0]  val_q;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            rd_idx_q, rd_idx_d;
  logic signed [VAL_W-1:0]  cell_q [CAPACITY];
  logic signed [VAL_W-1:0]  cell_d [CAPACITY];

  logic                     valid_q, valid_d;
  logic [STAT_W-1:0]        status_q, status_d;
  logic [CNT_W-1:0]         cnt_out_q, cnt_out_d;
  logic signed [VAL_W-1:0]  elem_q, elem_d;
  logic                     last_q, last_d;

  logic              empty, full, pos_ok, is_read;
  logic [CMPW-1:0]   pos_x, cnt_x, pos_m1;
  logic              ins_en, del_en, dec_en, rd_go, rd_last;
  logic [CW-1:0]     ins_at, del_at;
  logic [STAT_W-1:0] stat;
  logic [CW+CNT_W-1:0] cnt_ext;

  assign empty  = (count_q == '0);
  assign full   = (count_q == CAP_C);
  assign pos_x  = CMPW'(pos_q);
  assign cnt_x  = CMPW'(count_q);
  assign pos_m1 = pos_x - CMPW'(1);
  assign pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
  assign rd_last = ({1'b0, rd_idx_q} + {{CW{1'b0}}, 1'b1}) == {1'b0, count_q};

  always_comb begin
    ins_en  = 1'b0;
    del_en  = 1'b0;
    dec_en  = 1'b0;
    is_read = 1'b0;
    ins_at  = pos_m1[CW-1:0];
    del_at  = pos_m1[CW-1:0];
    stat    = ST_OK;
    case (mode_q)
      MODE_APPEND: begin
        ins_at = count_q;
        if (full) stat = ST_FULL;
        else      ins_en = 1'b1;
      end
      MODE_INSERT: begin
        if (empty)       stat = ST_EMPTY;
        else if (!pos_ok) stat = ST_BADPOS;
        else if (full)   stat = ST_FULL;
        else             ins_en = 1'b1;
      end
      MODE_DEL_LAST: begin
        if (empty) stat = ST_EMPTY;
        else       dec_en = 1'b1;
      end
      MODE_DEL_AT: begin
        if (empty)        stat = ST_EMPTY;
        else if (!pos_ok) stat = ST_BADPOS;
        else              del_en = 1'b1;
      end
      MODE_READ: begin
        if (empty) stat = ST_EMPTY;
        else       is_read = 1'b1;
      end
      default: begin
        stat = ST_OK;
      end
    endcase
  end

  assign rd_go = (ctl_i.exec && is_read) || ctl_i.step;
  assign sts_o.more = rd_go && !rd_last;

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic signed [VAL_W-1:0] prv, nxt;
    if (gi == 0) begin : g_first
      assign prv = '0;
    end else begin : g_prv
      assign prv = cell_q[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_end
      assign nxt = cell_q[gi];
    end else begin : g_nxt
      assign nxt = cell_q[gi+1];
    end

    always_comb begin
      cell_d[gi] = cell_q[gi];
      if (ctl_i.exec && ins_en) begin
        if (CW'(gi) == ins_at)      cell_d[gi] = val_q;
        else if (CW'(gi) > ins_at)  cell_d[gi] = prv;
      end else if (ctl_i.exec && del_en) begin
        if (CW'(gi) >= del_at)      cell_d[gi] = nxt;
      end else if (rd_go) begin
        if (CW'(gi) == count_q - CW_ONE)     cell_d[gi] = cell_q[0];
        else if (CW'(gi) < count_q - CW_ONE) cell_d[gi] = nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_q[i] <= cell_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      mode_q <= mode_i;
      pos_q  <= position_i;
      val_q  <= value_i;
    end
  end

  always_comb begin
    count_d  = count_q;
    rd_idx_d = rd_idx_q;
    if (ctl_i.load) begin
      rd_idx_d = '0;
    end else if (ctl_i.exec && ins_en) begin
      count_d = count_q + CW_ONE;
    end else if (ctl_i.exec && (del_en || dec_en)) begin
      count_d = count_q - CW_ONE;
    end
    if (rd_go) rd_idx_d = rd_idx_q + CW_ONE;
  end

  assign cnt_ext = {{CNT_W{1'b0}}, count_d};

  always_comb begin
    valid_d   = 1'b0;
    status_d  = status_q;
    cnt_out_d = cnt_out_q;
    elem_d    = elem_q;
    last_d    = last_q;
    if (rd_go) begin
      valid_d   = 1'b1;
      status_d  = ST_OK;
      cnt_out_d = cnt_ext[CNT_W-1:0];
      elem_d    = cell_q[0];
      last_d    = rd_last;
    end else if (ctl_i.exec) begin
      valid_d   = 1'b1;
      status_d  = stat;
      cnt_out_d = cnt_ext[CNT_W-1:0];
      elem_d    = '0;
      last_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_idx_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    cnt_out_q <= cnt_out_d;
    elem_q    <= elem_d;
    last_q    <= last_d;
  end

  assign valid_o   = valid_q;
  assign status_o  = status_q;
  assign count_o   = cnt_out_q;
  assign element_o = elem_q;
  assign last_o    = last_q;

endmodule

@@ dv/testbench.sv @@
// Testbench for positional_list_store_core: issues list commands over the
// start/busy handshake and checks every result beat against a shadow list.
// Depends on plst_pkg and the design sources.
`timescale 1ns / 1ps

module testbench;
  import plst_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int CLK_HALF = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
  localparam int RANDOM_ITEMS = 146;
  localparam int REPORT_CAP = 50;
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = MODE_READ + 1'b1;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = '1;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    status_e                 status;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] element;
    logic                    last;
  } beat_t;

  class list_shadow;
    logic signed [VAL_W-1:0] cells [LIST_DEPTH];
    int unsigned held;
    beat_t pending_beats[$];
    int mismatches;
    int beats_seen;
    int full_hits;
    int empty_hits;
    int badpos_hits;
    int readouts;

    function void push_beat(status_e st, logic signed [VAL_W-1:0] elem, logic fin);
      beat_t b;
      b.status = st;
      b.count = CNT_W'(held);
      b.element = elem;
      b.last = fin;
      pending_beats.push_back(b);
    endfunction

    function void apply_command(input logic [MODE_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic signed [VAL_W-1:0] val);
      status_e st;
      bit pos_ok;
      int i;
      st = ST_OK;
      pos_ok = (pos >= 1) && (pos <= held);
      case (op)
        MODE_APPEND: begin
          if (held >= LIST_DEPTH) begin
            st = ST_FULL;
          end else begin
            cells[held] = val;
            held++;
          end
        end
        MODE_INSERT: begin
          if (held == 0) begin
            st = ST_EMPTY;
          end else if (!pos_ok) begin
            st = ST_BADPOS;
          end else if (held >= LIST_DEPTH) begin
            st = ST_FULL;
          end else begin
            for (i = held; i >= pos; i--) cells[i] = cells[i-1];
            cells[pos-1] = val;
            held++;
          end
        end
        MODE_DEL_LAST: begin
          if (held == 0) st = ST_EMPTY;
          else held--;
        end
        MODE_DEL_AT: begin
          if (held == 0) begin
            st = ST_EMPTY;
          end else if (!pos_ok) begin
            st = ST_BADPOS;
          end else begin
            for (i = pos; i < held; i++) cells[i-1] = cells[i];
            held--;
          end
        end
        MODE_READ: begin
          if (held == 0) begin
            st = ST_EMPTY;
          end else begin
            readouts++;
            for (i = 0; i < held; i++) push_beat(ST_OK, cells[i], i + 1 == held);
            return;
          end
        end
        default: ;
      endcase
      case (st)
        ST_FULL:   full_hits++;
        ST_EMPTY:  empty_hits++;
        ST_BADPOS: badpos_hits++;
        default: ;
      endcase
      push_beat(st, '0, 1'b1);
    endfunction

    function void compare_beat(input logic [STAT_W-1:0] st, input logic [CNT_W-1:0] cnt,
                               input logic signed [VAL_W-1:0] elem, input logic fin);
      beat_t want;
      beats_seen++;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: unexpected beat: status %0d count %0d element %0d last %0d",
                   $time, st, cnt, elem, fin);
        return;
      end
      want = pending_beats.pop_front();
      if (want.status !== st || want.count !== cnt || want.element !== elem ||
          want.last !== fin) begin
        mismatches++;
        if (mismatches <= REPORT_CAP) begin
          $display("%0t: mismatch, expected status %0d count %0d element %0d last %0d",
                   $time, want.status, want.count, want.element, want.last);
          $display("%0t:           actual status %0d count %0d element %0d last %0d",
                   $time, st, cnt, elem, fin);
        end
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic [MODE_W-1:0]       mode_i = '0;
  logic [POS_W-1:0]        position_i = '0;
  logic signed [VAL_W-1:0] value_i = '0;
  logic                    busy_o;
  logic                    valid_o;
  logic [STAT_W-1:0]       status_o;
  logic [CNT_W-1:0]        count_o;
  logic signed [VAL_W-1:0] element_o;
  logic                    last_o;

  list_shadow shadow;
  int sender_idle_pct = 0;
  int cycle_count = 0;
  int commands_sent = 0;

  positional_list_store_core #(
    .CAPACITY(LIST_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .mode_i     (mode_i),
    .position_i (position_i),
    .value_i    (value_i),
    .valid_o    (valid_o),
    .status_o   (status_o),
    .count_o    (count_o),
    .element_o  (element_o),
    .last_o     (last_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (valid_o === 1'b1) shadow.compare_beat(status_o, count_o, element_o, last_o);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic issue(input logic [MODE_W-1:0] op, input logic [POS_W-1:0] pos,
                       input logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    mode_i <= op;
    position_i <= pos;
    value_i <= val;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    shadow.apply_command(op, pos, val);
    commands_sent++;
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    int unsigned span;
    span = (shadow.held == 0) ? 1 : shadow.held;
    case ($urandom_range(9))
      0: return POS_W'($urandom_range((1 << POS_W) - 1));
      1: return '0;
      2: return POS_W'(span + 1);
      default: return POS_W'($urandom_range(span, 1));
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_directed();
    issue(MODE_READ, 8'd0, 0);
    issue(MODE_DEL_LAST, 8'd0, 0);
    issue(MODE_DEL_AT, 8'd1, 0);
    issue(MODE_INSERT, 8'd1, 5);
    issue(MODE_APPEND, '0, VAL_MAX);
    issue(MODE_DEL_LAST, '1, '1);
    issue(MODE_APPEND, '1, VAL_MIN);
    issue(MODE_DEL_AT, 8'd1, 0);
    issue(MODE_APPEND, 8'd0, 0);
    issue(MODE_APPEND, 8'd0, -1);
    issue(MODE_INSERT, 8'd0, 7);
    issue(MODE_INSERT, 8'd3, 7);
    issue(MODE_DEL_AT, '1, 0);
    issue(MODE_INSERT, 8'd1, VAL_MIN);
    issue(MODE_INSERT, 8'd3, VAL_MAX);
    issue(MODE_READ, '1, '1);
    issue(MODE_DEL_AT, 8'd2, 0);
    issue(MODE_SPARE_LO, 8'd1, 1);
    issue(MODE_SPARE_HI, '1, VAL_MIN);
    issue(MODE_READ, 8'd0, 0);
  endtask

  task automatic run_random(input int budget);
    int sent;
    int r;
    logic [MODE_W-1:0] op;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(9);
      if (r == 0) begin
        while (shadow.held < LIST_DEPTH) begin
          if (shadow.held == 0 || $urandom_range(1))
            issue(MODE_APPEND, pick_position(), pick_value());
          else
            issue(MODE_INSERT, POS_W'($urandom_range(shadow.held, 1)), pick_value());
          sent++;
        end
        issue(MODE_APPEND, pick_position(), pick_value());
        issue(MODE_INSERT, POS_W'($urandom_range(LIST_DEPTH, 1)), pick_value());
        issue(MODE_READ, pick_position(), pick_value());
        sent += 3;
      end else if (r == 1) begin
        while (shadow.held > 0) begin
          if ($urandom_range(1)) issue(MODE_DEL_LAST, pick_position(), pick_value());
          else issue(MODE_DEL_AT, pick_position(), pick_value());
          sent++;
        end
        issue(MODE_DEL_LAST, pick_position(), pick_value());
        issue(MODE_READ, pick_position(), pick_value());
        sent += 2;
      end else begin
        r = $urandom_range(99);
        if (r < 25) op = MODE_APPEND;
        else if (r < 50) op = MODE_INSERT;
        else if (r < 60) op = MODE_DEL_LAST;
        else if (r < 75) op = MODE_DEL_AT;
        else if (r < 94) op = MODE_READ;
        else op = MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
        issue(op, pick_position(), pick_value());
        sent++;
      end
    end
  endtask

  initial begin
    shadow = new;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 35;
    run_directed();
    run_random(RANDOM_ITEMS);
    sender_idle_pct = 47;
    run_random(RANDOM_ITEMS);
    sender_idle_pct = 0;
    run_random(RANDOM_ITEMS);
    start_i <= 1'b0;

    while (shadow.pending_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Issued %0d commands (%0d read-outs) and checked %0d result beats.",
             commands_sent, shadow.readouts, shadow.beats_seen);
    $display("Rejections seen: %0d full, %0d empty, %0d bad position; %0d mismatches.",
             shadow.full_hits, shadow.empty_hits, shadow.badpos_hits, shadow.mismatches);
    if (shadow.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/plst_pkg.sv
design/plst_ctrl.sv
design/plst_datapath.sv
design/positional_list_store_core.sv
dv/testbench.sv
